@@ src/svw_pkg.sv @@
//------------------------------------------------------------------------------
// svw_pkg
// shared constants, types and the cordic angle table of the scaled sine block
//------------------------------------------------------------------------------
`default_nettype none

package svw_pkg;

   // number format and cordic length
   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int DATA_W        = 32;
   localparam int DIV_W         = DATA_W + FRAC_BITS;

   // angle reduction constants
   localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;
   localparam logic [63:0] TWO_PI_F   =
      (TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   localparam logic [63:0] BIAS_K     = ((64'd1 << 32) + TWO_PI_F - 64'd1) / TWO_PI_F;
   localparam logic [63:0] BIAS       = BIAS_K * TWO_PI_F;
   localparam int          MOD_STEPS  = $clog2(2 * BIAS_K + 2);
   localparam int          MOD_W      = 35;

   // cordic datapath widths and q30 constants
   localparam int ANG_W = 35;
   localparam int XY_W  = 34;
   localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [XY_W-1:0]  ONE_Q30     = 34'sd1073741824;
   localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;

   // fields that travel alongside the arithmetic
   typedef struct packed {
      logic signed [DATA_W-1:0] phase;
      logic signed [DATA_W-1:0] amplitude;
      logic signed [DATA_W-1:0] offset;
      logic                     zero;
      logic                     sat;
   } side_type;

   // atan(2^-i) in q30
   function automatic logic signed [ANG_W-1:0] atan_angle(input int i);
      logic signed [ANG_W-1:0] v;
      v = '0;
      case (i)
         0: v = 35'sd843314857;
         1: v = 35'sd497837829;
         2: v = 35'sd263043837;
         3: v = 35'sd133525159;
         4: v = 35'sd67021687;
         5: v = 35'sd33543516;
         6: v = 35'sd16775851;
         7: v = 35'sd8388437;
         8: v = 35'sd4194283;
         9: v = 35'sd2097149;
         default: begin
            if (i <= 30) begin
               v = 35'sd1 <<< (30 - i);
            end
         end
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ src/scaled_sine_wave_value.sv @@
//------------------------------------------------------------------------------
// scaled_sine_wave_value
// sin(position / period + phase) * amplitude + offset in signed q16.16
//------------------------------------------------------------------------------
// One request enters per cycle and one result leaves per cycle while the output
// is not stalled. Each request passes through the restoring divider stages, the
// modulo-two-pi subtract stages and the cordic micro-rotation stages. The whole
// pipeline halts while a result waits on rsp_tready; nothing is lost or repeated.
// A zero period returns the offset with the flag clear.
//------------------------------------------------------------------------------
`default_nettype none

module scaled_sine_wave_value
   import svw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // position, period, phase, amplitude, offset
   input  wire logic [159:0] req_tdata,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // wave_value
   output      logic [31:0]  rsp_tdata,
   // saturated
   output      logic [0:0]   rsp_tuser
);

   logic en;
   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;

   // unpack the request
   logic signed [DATA_W-1:0] position;
   logic signed [DATA_W-1:0] period;
   side_type                 req_side;
   always_comb begin
      position           = req_tdata[31:0];
      period             = req_tdata[63:32];
      req_side.phase     = req_tdata[95:64];
      req_side.amplitude = req_tdata[127:96];
      req_side.offset    = req_tdata[159:128];
      req_side.zero      = (period == '0);
      req_side.sat       = 1'b0;
   end

   logic             div_valid;
   logic [DIV_W-1:0] div_quo;
   logic             div_neg;
   side_type         div_side;

   svw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .position  (position),
      .period    (period),
      .in_side   (req_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_neg   (div_neg),
      .out_side  (div_side)
   );

   logic                    ang_valid;
   logic signed [ANG_W-1:0] ang;
   side_type                ang_side;

   svw_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_quo    (div_quo),
      .in_neg    (div_neg),
      .in_side   (div_side),
      .out_valid (ang_valid),
      .out_angle (ang),
      .out_side  (ang_side)
   );

   logic                     sin_valid;
   logic signed [DATA_W-1:0] sine;
   side_type                 sin_side;

   svw_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ang_valid),
      .in_angle  (ang),
      .in_side   (ang_side),
      .out_valid (sin_valid),
      .out_sine  (sine),
      .out_side  (sin_side)
   );

   logic signed [DATA_W-1:0] wave_value;
   logic                     saturated;

   svw_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sin_valid),
      .in_sine   (sine),
      .in_side   (sin_side),
      .out_valid (rsp_tvalid),
      .out_value (wave_value),
      .out_sat   (saturated)
   );

   assign rsp_tdata = wave_value;
   assign rsp_tuser = saturated;

endmodule

`default_nettype wire

@@ src/svw_div.sv @@
//------------------------------------------------------------------------------
// svw_div
// pipelined restoring divider, one quotient bit per stage, on magnitudes
//------------------------------------------------------------------------------
`default_nettype none

module svw_div
   import svw_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic signed [DATA_W-1:0] position,
   input  wire logic signed [DATA_W-1:0] period,
   input  wire side_type                 in_side,
   output      logic                     out_valid,
   output      logic [DIV_W-1:0]         out_quo,
   output      logic                     out_neg,
   output      side_type                 out_side
);

   logic             valid_ff [0:DIV_W];
   logic [DIV_W-1:0]  quo_ff  [0:DIV_W];
   logic [DATA_W-1:0] rem_ff  [0:DIV_W];
   logic [DATA_W-1:0] dv_ff   [0:DIV_W];
   logic             neg_ff   [0:DIV_W];
   side_type         side_ff  [0:DIV_W];

   logic signed [DIV_W-1:0] dividend;
   logic [DIV_W-1:0]        dend_mag_in;
   logic [DATA_W-1:0]       dv_mag_in;

   // operand magnitudes
   always_comb begin
      dividend    = {position, {FRAC_BITS{1'b0}}};
      dend_mag_in = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
      dv_mag_in   = period[DATA_W-1] ? DATA_W'(-period) : DATA_W'(period);
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         quo_ff[0]  <= dend_mag_in;
         rem_ff[0]  <= '0;
         dv_ff[0]   <= dv_mag_in;
         neg_ff[0]  <= position[DATA_W-1] ^ period[DATA_W-1];
         side_ff[0] <= in_side;
      end
   end

   // one quotient bit per stage
   for (genvar s = 0; s < DIV_W; s++) begin : g_stage
      logic [DATA_W-1:0] shl;
      logic [DATA_W:0]   diff;
      assign shl  = {rem_ff[s][DATA_W-2:0], quo_ff[s][DIV_W-1]};
      assign diff = {1'b0, shl} - {1'b0, dv_ff[s]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (en) begin
            rem_ff[s+1]  <= diff[DATA_W] ? shl : diff[DATA_W-1:0];
            quo_ff[s+1]  <= {quo_ff[s][DIV_W-2:0], ~diff[DATA_W]};
            dv_ff[s+1]   <= dv_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_W];
   assign out_quo   = quo_ff[DIV_W];
   assign out_neg   = neg_ff[DIV_W];
   assign out_side  = side_ff[DIV_W];

endmodule

`default_nettype wire

@@ src/svw_angle.sv @@
//------------------------------------------------------------------------------
// svw_angle
// quotient saturation, phase add, reduction modulo two pi and quadrant fold
//------------------------------------------------------------------------------
`default_nettype none

module svw_angle
   import svw_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [DIV_W-1:0]        in_quo,
   input  wire logic                    in_neg,
   input  wire side_type                in_side,
   output      logic                    out_valid,
   output      logic signed [ANG_W-1:0] out_angle,
   output      side_type                out_side
);

   localparam logic [MOD_W-1:0] MOD_C    = MOD_W'(TWO_PI_F);
   localparam logic [MOD_W-1:0] MOD_BIAS = MOD_W'(BIAS);

   logic             valid_ff [0:MOD_STEPS];
   logic [MOD_W-1:0] val_ff   [0:MOD_STEPS];
   side_type         side_ff  [0:MOD_STEPS];

   logic                    sat_q;
   logic signed [DATA_W-1:0] q;
   logic signed [DATA_W:0]   a_sum;
   logic [MOD_W-1:0]         val_in;
   side_type                 side_in;

   // saturate the quotient, add phase and bias to a nonnegative value
   always_comb begin
      if (in_neg) begin
         sat_q = in_quo > (DIV_W'(1) << (DATA_W - 1));
      end else begin
         sat_q = in_quo > ((DIV_W'(1) << (DATA_W - 1)) - DIV_W'(1));
      end
      if (sat_q) begin
         q = in_neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         q = in_neg ? -$signed(in_quo[DATA_W-1:0]) : $signed(in_quo[DATA_W-1:0]);
      end
      a_sum       = {q[DATA_W-1], q} + {in_side.phase[DATA_W-1], in_side.phase};
      val_in      = MOD_W'(a_sum) + MOD_BIAS;
      side_in     = in_side;
      side_in.sat = sat_q & ~in_side.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         val_ff[0]  <= val_in;
         side_ff[0] <= side_in;
      end
   end

   // conditional subtract of the modulus times a power of two, largest first
   for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
      logic [MOD_W-1:0] sub;
      assign sub = MOD_C << (MOD_STEPS - 1 - j);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            valid_ff[j+1] <= valid_ff[j];
         end
         if (en) begin
            val_ff[j+1]  <= (val_ff[j] >= sub) ? val_ff[j] - sub : val_ff[j];
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   // rescale to q30 and fold into the half circle around zero
   logic signed [ANG_W-1:0] r;
   logic signed [ANG_W-1:0] angle_in;
   always_comb begin
      r = $signed(ANG_W'(val_ff[MOD_STEPS])) <<< (30 - FRAC_BITS);
      if (r > PI_Q30) begin
         r = r - (PI_Q30 <<< 1);
      end
      if (r > HALF_PI_Q30) begin
         angle_in = PI_Q30 - r;
      end else if (r < -HALF_PI_Q30) begin
         angle_in = -PI_Q30 - r;
      end else begin
         angle_in = r;
      end
   end

   logic                    out_valid_ff;
   logic signed [ANG_W-1:0] angle_ff;
   side_type                side_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[MOD_STEPS];
      end
      if (en) begin
         angle_ff    <= angle_in;
         side_out_ff <= side_ff[MOD_STEPS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = angle_ff;
   assign out_side  = side_out_ff;

endmodule

`default_nettype wire

@@ src/svw_cordic.sv @@
//------------------------------------------------------------------------------
// svw_cordic
// rotation mode cordic, one micro-rotation per stage, clamped sine out
//------------------------------------------------------------------------------
`default_nettype none

module svw_cordic
   import svw_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic signed [ANG_W-1:0]  in_angle,
   input  wire side_type                 in_side,
   output      logic                     out_valid,
   output      logic signed [DATA_W-1:0] out_sine,
   output      side_type                 out_side
);

   logic                    valid_ff [0:CORDIC_STAGES];
   logic signed [XY_W-1:0]  x_ff     [0:CORDIC_STAGES];
   logic signed [XY_W-1:0]  y_ff     [0:CORDIC_STAGES];
   logic signed [ANG_W-1:0] z_ff     [0:CORDIC_STAGES];
   side_type                side_ff  [0:CORDIC_STAGES];

   // start vector on the x axis with the gain folded in
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]    <= GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= in_angle;
         side_ff[0] <= in_side;
      end
   end

   // micro-rotations
   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
      logic signed [XY_W-1:0]  xs;
      logic signed [XY_W-1:0]  ys;
      logic signed [ANG_W-1:0] step;
      assign xs   = x_ff[s] >>> s;
      assign ys   = y_ff[s] >>> s;
      assign step = atan_angle(s);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (en) begin
            if (!z_ff[s][ANG_W-1]) begin
               x_ff[s+1] <= x_ff[s] - ys;
               y_ff[s+1] <= y_ff[s] + xs;
               z_ff[s+1] <= z_ff[s] - step;
            end else begin
               x_ff[s+1] <= x_ff[s] + ys;
               y_ff[s+1] <= y_ff[s] - xs;
               z_ff[s+1] <= z_ff[s] + step;
            end
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   // clamp the sine to plus or minus one
   logic signed [XY_W-1:0]   y_last;
   logic signed [DATA_W-1:0] sine_in;
   always_comb begin
      y_last = y_ff[CORDIC_STAGES];
      if (y_last > ONE_Q30) begin
         sine_in = DATA_W'(ONE_Q30);
      end else if (y_last < -ONE_Q30) begin
         sine_in = DATA_W'(-ONE_Q30);
      end else begin
         sine_in = DATA_W'(y_last);
      end
   end

   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] sine_ff;
   side_type                 side_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[CORDIC_STAGES];
      end
      if (en) begin
         sine_ff     <= sine_in;
         side_out_ff <= side_ff[CORDIC_STAGES];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_sine  = sine_ff;
   assign out_side  = side_out_ff;

endmodule

`default_nettype wire

@@ src/svw_scale.sv @@
//------------------------------------------------------------------------------
// svw_scale
// amplitude multiply, rounding, offset add and output saturation
//------------------------------------------------------------------------------
`default_nettype none

module svw_scale
   import svw_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic signed [DATA_W-1:0] in_sine,
   input  wire side_type                 in_side,
   output      logic                     out_valid,
   output      logic signed [DATA_W-1:0] out_value,
   output      logic                     out_sat
);

   localparam int PROD_W = 2 * DATA_W;
   localparam int RND_W  = PROD_W - 30;
   localparam int SUM_W  = RND_W + 1;

   localparam logic signed [SUM_W-1:0] SUM_MAX =
      $signed(SUM_W'({1'b0, {(DATA_W-1){1'b1}}}));
   localparam logic signed [SUM_W-1:0] SUM_MIN =
      -$signed(SUM_W'(1) << (DATA_W - 1));

   logic                     prod_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   side_type                 side_ff;

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= in_valid;
      end
      if (en) begin
         prod_ff <= in_sine * in_side.amplitude;
         side_ff <= in_side;
      end
   end

   // round half up, add offset, saturate
   logic signed [PROD_W-1:0] rnd_full;
   logic signed [RND_W-1:0]  rnd;
   logic signed [SUM_W-1:0]  sum;
   logic signed [DATA_W-1:0] value_in;
   logic                     sat_in;
   always_comb begin
      rnd_full = (prod_ff + (PROD_W'(1) <<< 29)) >>> 30;
      rnd      = rnd_full[RND_W-1:0];
      sum      = SUM_W'(rnd) + SUM_W'(side_ff.offset);
      sat_in   = side_ff.sat;
      if (side_ff.zero) begin
         value_in = side_ff.offset;
         sat_in   = 1'b0;
      end else if (sum > SUM_MAX) begin
         value_in = {1'b0, {(DATA_W-1){1'b1}}};
         sat_in   = 1'b1;
      end else if (sum < SUM_MIN) begin
         value_in = {1'b1, {(DATA_W-1){1'b0}}};
         sat_in   = 1'b1;
      end else begin
         value_in = sum[DATA_W-1:0];
      end
   end

   // output register
   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic                     sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= prod_valid_ff;
      end
      if (en) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = value_ff;
   assign out_sat   = sat_ff;

endmodule

`default_nettype wire

@@ src/svw_checker.sv @@
//------------------------------------------------------------------------------
// svw_checker
// port-level checks of the scaled sine block, bound to the top level
//------------------------------------------------------------------------------
`default_nettype none

module svw_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [31:0]  rsp_tdata,
   input wire logic [0:0]   rsp_tuser
);

   // no result comes out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // the pipeline takes requests exactly when its output can move
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow output stall");

   // a stalled result stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("stalled result dropped");

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind scaled_sine_wave_value svw_checker u_svw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ tb/sv/svw_checker.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// svw_scoreboard
// watches the request and result streams, predicts each wave value and
// compares it field by field with what the block returns, in order
//------------------------------------------------------------------------------
`default_nettype none

module svw_scoreboard (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [159:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [31:0]  rsp_tdata,
   input  wire logic [0:0]   rsp_tuser,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      logic [31:0] wave_value;
      logic        saturated;
   } wave_type;

   wave_type wave_queue[$];

   localparam longint TWO_PI_Q32 = 64'sd26986075409;
   localparam longint PI_Q30     = 64'sd3373259426;
   localparam longint HALF_PI    = 64'sd1686629713;
   localparam longint ONE_Q30    = 64'sd1073741824;
   localparam longint GAIN_Q30   = 64'sd652032874;
   localparam longint S32_MAX    = 64'sd2147483647;
   localparam longint S32_MIN    = -64'sd2147483648;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint turn_angle(int i);
      longint atan_q30 [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                               33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return atan_q30[i];
      return longint'(1) << (30 - i);
   endfunction

   // cordic rotation mode, q30, floor shifts
   function automatic longint cordic_sine(longint ang);
      longint x, y, z, xs, ys;
      x = GAIN_Q30;
      y = 0;
      z = ang;
      for (int i = 0; i < 16; i++) begin
         xs = floor_shr(x, i);
         ys = floor_shr(y, i);
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - turn_angle(i);
         end else begin
            x = x + ys; y = y - xs; z = z + turn_angle(i);
         end
      end
      if (y > ONE_Q30) y = ONE_Q30;
      if (y < -ONE_Q30) y = -ONE_Q30;
      return y;
   endfunction

   function automatic wave_type predict_wave(logic [159:0] d);
      longint position, period, phase, amplitude, offset;
      longint two_pi_f, q, r, s, prod, res;
      logic flag;
      wave_type w;
      position  = longint'($signed(d[31:0]));
      period    = longint'($signed(d[63:32]));
      phase     = longint'($signed(d[95:64]));
      amplitude = longint'($signed(d[127:96]));
      offset    = longint'($signed(d[159:128]));
      flag = 1'b0;
      if (period == 0) begin
         res = offset;
      end else begin
         two_pi_f = (TWO_PI_Q32 + (longint'(1) << 15)) >>> 16;
         // division truncates toward zero in sv as well
         q = (position * 65536) / period;
         if (q > S32_MAX) begin q = S32_MAX; flag = 1'b1; end
         if (q < S32_MIN) begin q = S32_MIN; flag = 1'b1; end
         r = (q + phase) % two_pi_f;
         if (r < 0) r += two_pi_f;
         r = r * 16384;
         if (r > PI_Q30) r -= 2 * PI_Q30;
         if (r > HALF_PI) r = PI_Q30 - r;
         else if (r < -HALF_PI) r = -PI_Q30 - r;
         s = cordic_sine(r);
         prod = floor_shr(s * amplitude + (longint'(1) << 29), 30);
         res = prod + offset;
         if (res > S32_MAX) begin res = S32_MAX; flag = 1'b1; end
         if (res < S32_MIN) begin res = S32_MIN; flag = 1'b1; end
      end
      w.wave_value = res[31:0];
      w.saturated  = flag;
      return w;
   endfunction

   assign pending = wave_queue.size();

   // predict on request, compare on result
   always @(posedge clock) begin
      wave_type want;
      if (reset) begin
         wave_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) wave_queue = {wave_queue, predict_wave(req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            if (wave_queue.size() == 0) begin
               $error("result with no request outstanding: wave_value %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = wave_queue.pop_front();
               if (rsp_tdata !== want.wave_value || rsp_tuser[0] !== want.saturated) begin
                  if (rsp_tdata !== want.wave_value)
                     $error("wave_value expected %h actual %h", want.wave_value, rsp_tdata);
                  if (rsp_tuser[0] !== want.saturated)
                     $error("saturated expected %b actual %b", want.saturated, rsp_tuser[0]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_scaled_sine_wave_value.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_scaled_sine_wave_value
// drives directed and random requests with random gaps and result stalls,
// including one long stall that backs up the pipeline, and gives the verdict
//------------------------------------------------------------------------------
`default_nettype none

module tb_scaled_sine_wave_value;

   localparam int LATENCY   = 86;
   localparam int N_RANDOM  = 1530;
   localparam int IDLE_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // position, period, phase, amplitude, offset
   logic [159:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // wave_value
   logic [31:0]  rsp_tdata;
   // saturated
   logic [0:0]   rsp_tuser;
   int           fail_count, pending, idle_cycles;
   logic         long_hold = 1'b0;

   scaled_sine_wave_value dut (.*);

   svw_scoreboard u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0001;
         4, 5: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
         default: return $urandom();
      endcase
   endfunction

   // one request, with a random gap before it
   task automatic send_request(logic [31:0] pos, per, ph, amp, off);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {off, amp, ph, per, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver: random stalls, one long hold-off early on
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 99) < 30);
      end
   end

   // long hold-off while the sender keeps offering requests
   initial begin
      @(posedge clock);
      wait (!reset);
      repeat (300) @(posedge clock);
      long_hold <= 1'b1;
      repeat (400) @(posedge clock);
      long_hold <= 1'b0;
   end

   // watchdog on accepted handshakes
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("scaled_sine_wave_value verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] per;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: zero period, extremes, most negative quotient, large phase
      send_request(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h1234_5678);
      send_request(32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      send_request(32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h0001_0000, 32'h0);
      send_request(32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0001_0000, 32'h0);
      send_request(32'h7fff_ffff, 32'h0000_0001, 32'h0, 32'h0001_0000, 32'h0);
      send_request(32'h0, 32'h0001_0000, 32'h7fff_ffff, 32'h0001_0000, 32'h0);
      send_request(32'h0, 32'h0001_0000, 32'h8000_0000, 32'h0001_0000, 32'h0);
      send_request(32'h0, 32'h0001_0000, 32'h0001_921f, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(32'h0, 32'h0001_0000, 32'h0001_921f, 32'h8000_0000, 32'h8000_0000);
      send_request(32'h0, 32'h0001_0000, 32'hfffe_6de1, 32'h7fff_ffff, 32'h8000_0000);
      send_request(32'h0, 32'h0001_0000, 32'h0003_243f, 32'h0001_0000, 32'h0);
      send_request(32'h0, 32'h0001_0000, 32'h0006_487f, 32'h0001_0000, 32'h0);
      send_request(32'h0001_0000, 32'h0004_0000, 32'h0, 32'hffff_ffff, 32'h0000_0001);
      send_request(32'hffff_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h7fff_ffff);
      send_request(32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      for (int n = 0; n < N_RANDOM; n++) begin
         per = pick_value();
         send_request(pick_value(), per, pick_value(), pick_value(), pick_value());
      end
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("scaled_sine_wave_value verification clean");
      end else begin
         $display("scaled_sine_wave_value verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ scaled_sine_wave_value.f @@
src/svw_pkg.sv
src/svw_div.sv
src/svw_angle.sv
src/svw_cordic.sv
src/svw_scale.sv
src/scaled_sine_wave_value.sv
src/svw_checker.sv
tb/sv/svw_checker.sv
tb/sv/tb_scaled_sine_wave_value.sv
